// File: design/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types, constants and tables for the axis-angle point rotator.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam int CoordW  = 24;
  localparam int AxisW   = 16;
  localparam int AngleW  = 15;
  localparam int EntryW  = 18;
  localparam int CfgIdxW = 4;
  localparam int CfgW    = 16;
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int CordicSteps = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_AXIS_X = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_AXIS_Y = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_AXIS_Z = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_ANGLE  = 4'd3;

  localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;
  localparam logic signed [19:0] PI_Q16      = 20'sd205887;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [EntryW-1:0] ENTRY_ONE = 18'sd16384;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic                     last_point;
  } in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] rotated_x;
    logic signed [CoordW-1:0] rotated_y;
    logic signed [CoordW-1:0] rotated_z;
    logic                     last_out;
  } out_t;

  typedef logic [EntryW-1:0] ent_t;
  typedef ent_t [8:0] mat_t;

  typedef enum logic [2:0] {
    MG_IDLE,
    MG_INIT,
    MG_ROT,
    MG_FIX,
    MG_MUL1,
    MG_MUL2
  } mg_state_t;

  function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
    logic signed [19:0] v;
    case (i)
      4'd0:  v = 20'sd51472;
      4'd1:  v = 20'sd30386;
      4'd2:  v = 20'sd16055;
      4'd3:  v = 20'sd8150;
      4'd4:  v = 20'sd4091;
      4'd5:  v = 20'sd2047;
      4'd6:  v = 20'sd1024;
      4'd7:  v = 20'sd512;
      4'd8:  v = 20'sd256;
      4'd9:  v = 20'sd128;
      4'd10: v = 20'sd64;
      4'd11: v = 20'sd32;
      4'd12: v = 20'sd16;
      4'd13: v = 20'sd8;
      4'd14: v = 20'sd4;
      4'd15: v = 20'sd2;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: design/arp_matgen.sv
// ----------------------------------------------------------------------------
// arp_matgen
// Config registers, CORDIC cos/sin and sequential build of the 3x3 matrix.
// ----------------------------------------------------------------------------
module arp_matgen (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [arp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [arp_pkg::CfgW-1:0]     cfg_wdata,
  output arp_pkg::mat_t                mat,
  output logic                         busy
);
  import arp_pkg::*;

  mg_state_t state_r, state_nxt;

  logic signed [AxisW-1:0]  ax_r, ay_r, az_r;
  logic signed [AngleW-1:0] ang_r;
  logic signed [19:0]       x_r, y_r, z_r;
  logic [3:0]               it_r, k_r;
  logic signed [17:0]       c_r, s_r;
  logic signed [18:0]       omc_r;
  logic signed [31:0]       prod_r;
  logic signed [34:0]       lin_r;
  mat_t                     mat_r;

  logic cfg_hit;
  assign cfg_hit = cfg_we && (cfg_index <= REG_ANGLE);

  // angle folding
  logic signed [19:0] z0, zf;
  logic               neg0;
  always_comb begin
    z0 = $signed({ang_r[AngleW-1], ang_r, 4'b0000});
    zf = z0;
    neg0 = 1'b0;
    if (z0 > HALF_PI_Q16) begin
      zf = z0 - PI_Q16;
      neg0 = 1'b1;
    end else if (z0 < -HALF_PI_Q16) begin
      zf = z0 + PI_Q16;
      neg0 = 1'b1;
    end
  end
  logic neg_r;

  // final rounding of cordic outputs
  logic signed [19:0] cx, sy;
  logic signed [17:0] cq, sq;
  always_comb begin
    cx = (x_r + 20'sd2) >>> 2;
    sy = (y_r + 20'sd2) >>> 2;
    cq = neg_r ? -cx[17:0] : cx[17:0];
    sq = neg_r ? -sy[17:0] : sy[17:0];
  end

  // operand selection for entry k
  logic signed [AxisW-1:0] ai, aj, al;
  logic                    lneg, lzero, diag;
  always_comb begin
    ai = ax_r; aj = ax_r; al = ax_r; lneg = 1'b0; lzero = 1'b0; diag = 1'b0;
    case (k_r)
      4'd0: begin ai = ax_r; aj = ax_r; lzero = 1'b1; diag = 1'b1; end
      4'd1: begin ai = ax_r; aj = ay_r; al = az_r; lneg = 1'b1; end
      4'd2: begin ai = ax_r; aj = az_r; al = ay_r; end
      4'd3: begin ai = ax_r; aj = ay_r; al = az_r; end
      4'd4: begin ai = ay_r; aj = ay_r; lzero = 1'b1; diag = 1'b1; end
      4'd5: begin ai = ay_r; aj = az_r; al = ax_r; lneg = 1'b1; end
      4'd6: begin ai = ax_r; aj = az_r; al = ay_r; lneg = 1'b1; end
      4'd7: begin ai = ay_r; aj = az_r; al = ax_r; end
      4'd8: begin ai = az_r; aj = az_r; lzero = 1'b1; diag = 1'b1; end
      default: begin lzero = 1'b1; end
    endcase
  end

  logic signed [31:0] pij;
  logic signed [33:0] las;
  logic signed [34:0] lin_nxt;
  assign pij = ai * aj;
  assign las = al * s_r;
  always_comb begin
    if (lzero) lin_nxt = '0;
    else if (lneg) lin_nxt = -35'(las);
    else lin_nxt = 35'(las);
  end

  logic signed [50:0] pm;
  logic signed [55:0] psum;
  logic signed [27:0] prnd;
  logic signed [EntryW-1:0] ent;
  logic diag_r;
  assign pm = prod_r * omc_r;
  always_comb begin
    psum = 56'(pm) + (56'(lin_r) <<< 14) + (diag_r ? (56'(c_r) <<< 28) : 56'sd0)
         + 56'sd134217728;
    prnd = psum[55:28];
    if (prnd > 28'sd131071) ent = 18'sd131071;
    else if (prnd < -28'sd131072) ent = -18'sd131072;
    else ent = prnd[17:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= MG_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      MG_IDLE: state_nxt = MG_IDLE;
      MG_INIT: state_nxt = MG_ROT;
      MG_ROT:  if (it_r == 4'(CordicSteps - 1)) state_nxt = MG_FIX;
      MG_FIX:  state_nxt = MG_MUL1;
      MG_MUL1: state_nxt = MG_MUL2;
      MG_MUL2: state_nxt = (k_r == 4'd8) ? MG_IDLE : MG_MUL1;
      default: state_nxt = MG_IDLE;
    endcase
    // a write restarts the build
    if (cfg_hit) state_nxt = MG_INIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0;
      ay_r <= '0;
      az_r <= 16'sd16384;
      ang_r <= '0;
      for (int i = 0; i < 9; i++) mat_r[i] <= (i % 4 == 0) ? ENTRY_ONE : '0;
    end else begin
      if (cfg_hit) begin
        case (cfg_index)
          REG_AXIS_X: ax_r <= cfg_wdata;
          REG_AXIS_Y: ay_r <= cfg_wdata;
          REG_AXIS_Z: az_r <= cfg_wdata;
          REG_ANGLE:  ang_r <= cfg_wdata[AngleW-1:0];
          default: ;
        endcase
      end
      if (state_r == MG_MUL2 && !cfg_hit) mat_r[k_r] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      MG_INIT: begin
        x_r <= CORDIC_GAIN;
        y_r <= '0;
        z_r <= zf;
        neg_r <= neg0;
        it_r <= '0;
      end
      MG_ROT: begin
        if (z_r >= 0) begin
          x_r <= x_r - (y_r >>> it_r);
          y_r <= y_r + (x_r >>> it_r);
          z_r <= z_r - atan_q16(it_r);
        end else begin
          x_r <= x_r + (y_r >>> it_r);
          y_r <= y_r - (x_r >>> it_r);
          z_r <= z_r + atan_q16(it_r);
        end
        it_r <= it_r + 4'd1;
      end
      MG_FIX: begin
        c_r <= cq;
        s_r <= sq;
        omc_r <= 19'sd16384 - 19'(cq);
        k_r <= '0;
      end
      MG_MUL1: begin
        prod_r <= pij;
        lin_r <= lin_nxt;
        diag_r <= diag;
      end
      MG_MUL2: k_r <= k_r + 4'd1;
      default: ;
    endcase
  end

  assign mat  = mat_r;
  assign busy = (state_r != MG_IDLE);

endmodule

// File: design/arp_fifo.sv
// ----------------------------------------------------------------------------
// arp_fifo
// Short point queue between the accept front and the multiply back end.
// ----------------------------------------------------------------------------
module arp_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  arp_pkg::in_t  push_data,
  input  logic          pop,
  output arp_pkg::in_t  head,
  output logic          nonempty,
  output logic          full
);
  import arp_pkg::*;

  in_t                 mem_r [FifoDepth];
  logic [FifoPtrW-1:0] wp_r, rp_r;
  logic [FifoPtrW:0]   cnt_r;

  logic do_pop;
  assign do_pop = pop && nonempty;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (FifoPtrW+1)'(push) - (FifoPtrW+1)'(do_pop);
    end
  end

  assign head     = mem_r[rp_r];
  assign nonempty = (cnt_r != '0);
  assign full     = (cnt_r == (FifoPtrW+1)'(FifoDepth));

endmodule

// File: design/arp_back.sv
// ----------------------------------------------------------------------------
// arp_back
// Two-stage matrix-vector multiply with rounding and saturation.
// ----------------------------------------------------------------------------
module arp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  arp_pkg::in_t  pt,
  input  arp_pkg::mat_t mat,
  output logic          out_vld,
  output arp_pkg::out_t res
);
  import arp_pkg::*;

  logic signed [41:0] p_r [9];
  logic               v1_r, last1_r, v2_r;
  out_t               res_r;

  logic signed [CoordW-1:0] pts [3];
  assign pts[0] = pt.point_x;
  assign pts[1] = pt.point_y;
  assign pts[2] = pt.point_z;

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p_r[3*r+c] <= $signed(mat[3*r+c]) * pts[c];
      end
    end
    last1_r <= pt.last_point;
  end

  logic signed [43:0]       acc [3];
  logic signed [CoordW-1:0] sat [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 44'(p_r[3*r]) + 44'(p_r[3*r+1]) + 44'(p_r[3*r+2]) + 44'sd8192;
      acc[r] = acc[r] >>> 14;
      if (acc[r] > 44'sd8388607) sat[r] = 24'sd8388607;
      else if (acc[r] < -44'sd8388608) sat[r] = -24'sd8388608;
      else sat[r] = acc[r][CoordW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    res_r.rotated_x <= sat[0];
    res_r.rotated_y <= sat[1];
    res_r.rotated_z <= sat[2];
    res_r.last_out  <= last1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  assign out_vld = v2_r;
  assign res     = res_r;

endmodule

// File: design/axis_angle_point_rotator.sv
// ----------------------------------------------------------------------------
// axis_angle_point_rotator
// Rotates 3D points by a cached Rodrigues matrix built from axis and angle.
// ----------------------------------------------------------------------------
// accepted points pass the queue, product and result registers to out_strobe
// throughput: one point per cycle unless busy; queue drained every cycle
// config write rebuilds the matrix; busy in INIT, ROT, FIX, MUL1/MUL2 per entry
// reset: synchronous; queue, valids cleared; axis +z, angle 0, matrix identity
// ----------------------------------------------------------------------------
module axis_angle_point_rotator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  arp_pkg::in_t                 in_data,
  output logic                         out_strobe,
  output arp_pkg::out_t                out_data,
  input  logic                         cfg_we,
  input  logic [arp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [arp_pkg::CfgW-1:0]     cfg_wdata
);
  import arp_pkg::*;

  mat_t mat;
  logic mg_busy, q_full, q_ne, accept;
  in_t  head;

  arp_matgen u_matgen (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .mat, .busy(mg_busy)
  );

  assign busy   = mg_busy || q_full;
  assign accept = start && !busy;

  arp_fifo u_fifo (
    .clk, .rst_n, .push(accept), .push_data(in_data), .pop(1'b1),
    .head, .nonempty(q_ne), .full(q_full)
  );

  arp_back u_back (
    .clk, .rst_n, .in_vld(q_ne), .pt(head), .mat, .out_vld(out_strobe), .res(out_data)
  );

endmodule

// File: design/arp_checker.sv
// ----------------------------------------------------------------------------
// arp_checker
// Port-level checks on accept-to-result timing, last flag, config busy and reset.
// ----------------------------------------------------------------------------
module arp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input arp_pkg::in_t                 in_data,
  input logic                         out_strobe,
  input arp_pkg::out_t                out_data,
  input logic                         cfg_we,
  input logic [arp_pkg::CfgIdxW-1:0]  cfg_index,
  input logic [arp_pkg::CfgW-1:0]     cfg_wdata
);
  import arp_pkg::*;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_strobe)
    else $error("word not delivered three cycles after accept");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 (out_data.last_out == $past(in_data.last_point, 3)))
    else $error("last flag not carried through");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == REG_AXIS_X || cfg_index == REG_AXIS_Y ||
     cfg_index == REG_AXIS_Z || cfg_index == REG_ANGLE)) |=> busy)
    else $error("no busy after config write");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("word out of reset");

endmodule

bind axis_angle_point_rotator arp_checker u_chk (.*);
